[hw/rtl/pnorm_pkg.sv]
// pnorm_pkg: shared types and constants of the peak normalizer
// used by pnorm_front, pnorm_fifo, pnorm_back and peak_normalizer_core
// no dependencies
package pnorm_pkg;

	// width of the stored gain and the split used by the apply multiplier
	localparam int GAIN_BITS    = 40;
	localparam int GAIN_LO_BITS = 20;
	localparam int GAIN_HI_BITS = GAIN_BITS - GAIN_LO_BITS;

	// queue between front and back
	localparam int QPTR_W = 2;
	localparam int QDEPTH = 1 << QPTR_W;

	// input func codes
	localparam logic FUNC_MEASURE = 1'b0;
	localparam logic FUNC_APPLY   = 1'b1;

	// queue entry kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_GAIN   = 1'b1;

	// queue entry: a sample to scale, or a new gain to install
	typedef struct packed {
		logic                 kind;
		logic                 last;
		logic [GAIN_BITS-1:0] data;
	} q_entry_t;

endpackage

[hw/rtl/pnorm_div.sv]
// pnorm_div: restoring divider, one quotient bit per cycle
// no package dependencies
module pnorm_div #(
	parameter int NUM_W = 39,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one trial subtraction per cycle
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quo  = {quo_q[NUM_W-2:0], ge};

endmodule

[hw/rtl/pnorm_front.sv]
// pnorm_front: accepts items, tracks the measure-pass peak, computes the gain
// depends on pnorm_pkg and pnorm_div
module pnorm_front #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [SAMPLE_BITS-2:0]     target,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_func,
	input  logic [SAMPLE_BITS-1:0]     in_sample,
	input  logic                       in_last,
	output logic                       push_valid,
	input  logic                       push_ready,
	output pnorm_pkg::q_entry_t        push_entry
);

	localparam int QW = SAMPLE_BITS - 1 + GAIN_FRAC_BITS;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]                     state_q;
	logic [SAMPLE_BITS-1:0]         peak_q;
	logic [pnorm_pkg::GAIN_BITS-1:0] gain_q;
	logic [SAMPLE_BITS-1:0]         mag;
	logic [SAMPLE_BITS-1:0]         peak_next;
	logic                           accept;
	logic                           meas_last;
	logic                           div_start;
	logic                           div_done;
	logic [QW-1:0]                  quo;
	logic [pnorm_pkg::GAIN_BITS-1:0] gain_sat;

	// magnitude and running maximum
	assign mag       = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
	assign peak_next = (mag > peak_q) ? mag : peak_q;

	assign in_ready  = (state_q == ST_RUN) && push_ready;
	assign accept    = in_valid && in_ready;
	assign meas_last = accept && (in_func == pnorm_pkg::FUNC_MEASURE) && in_last;
	assign div_start = meas_last && (peak_next != '0);

	pnorm_div #(
		.NUM_W(QW),
		.DEN_W(SAMPLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({target, {GAIN_FRAC_BITS{1'b0}}}),
		.den   (peak_next),
		.done  (div_done),
		.quo   (quo)
	);

	// clamp the quotient to the gain register
	generate
		if (QW > pnorm_pkg::GAIN_BITS) begin : g_clamp
			assign gain_sat = (|quo[QW-1:pnorm_pkg::GAIN_BITS]) ? '1
				: quo[pnorm_pkg::GAIN_BITS-1:0];
		end else begin : g_noclamp
			assign gain_sat = pnorm_pkg::GAIN_BITS'(quo);
		end
	endgenerate

	// sequencer and peak register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			peak_q  <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (accept && (in_func == pnorm_pkg::FUNC_MEASURE)) begin
						peak_q <= in_last ? '0 : peak_next;
					end
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (meas_last) begin
						state_q <= ST_LOAD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (push_ready) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// gain waiting to be sent to the back
	always_ff @(posedge clk) begin
		if (meas_last && !div_start) begin
			gain_q <= '0;
		end else if (div_done) begin
			gain_q <= gain_sat;
		end
	end

	// queue request: apply samples in run state, the new gain in load state
	always_comb begin
		push_entry = '0;
		push_valid = 1'b0;
		if (state_q == ST_LOAD) begin
			push_valid      = 1'b1;
			push_entry.kind = pnorm_pkg::KIND_GAIN;
			push_entry.data = gain_q;
		end else begin
			push_valid      = accept && (in_func == pnorm_pkg::FUNC_APPLY);
			push_entry.kind = pnorm_pkg::KIND_SAMPLE;
			push_entry.last = in_last;
			push_entry.data = {{(pnorm_pkg::GAIN_BITS - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}},
				in_sample};
		end
	end

endmodule

[hw/rtl/pnorm_fifo.sv]
// pnorm_fifo: short queue of entries between front and back
// depends on pnorm_pkg
module pnorm_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  pnorm_pkg::q_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output pnorm_pkg::q_entry_t pop_entry
);

	pnorm_pkg::q_entry_t         mem_q [pnorm_pkg::QDEPTH];
	logic [pnorm_pkg::QPTR_W-1:0] wptr_q;
	logic [pnorm_pkg::QPTR_W-1:0] rptr_q;
	logic [pnorm_pkg::QPTR_W:0]   count_q;
	logic                         push;
	logic                         pop;

	assign push_ready = count_q != (pnorm_pkg::QPTR_W + 1)'(pnorm_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

endmodule

[hw/rtl/pnorm_back.sv]
// pnorm_back: holds the gain, scales samples and saturates them
// depends on pnorm_pkg
module pnorm_back #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  pnorm_pkg::q_entry_t    pop_entry,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] out_sample,
	output logic                   out_last
);

	localparam int PW = SAMPLE_BITS + pnorm_pkg::GAIN_LO_BITS + 1;
	localparam int SW = SAMPLE_BITS + pnorm_pkg::GAIN_BITS + 1;
	localparam int TW = SW - SAMPLE_BITS + 1;

	logic [pnorm_pkg::GAIN_BITS-1:0] gain_q;
	logic                            adv;
	logic                            pop;
	logic signed [SAMPLE_BITS-1:0]   smp;
	logic                            valid_s1;
	logic                            last_s1;
	logic signed [PW-1:0]            p_lo_s1;
	logic signed [PW-1:0]            p_hi_s1;
	logic                            valid_s2;
	logic                            last_s2;
	logic signed [SW-1:0]            sum_s2;
	logic signed [SW-1:0]            shifted;
	logic [TW-1:0]                   top_bits;
	logic [SAMPLE_BITS-1:0]          sat;
	logic                            out_valid_q;
	logic [SAMPLE_BITS-1:0]          sample_q;
	logic                            last_q;

	// the whole pipe moves when the output register is free or drained
	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;
	assign pop       = pop_valid && adv;
	assign smp       = $signed(pop_entry.data[SAMPLE_BITS-1:0]);

	// gain register, replaced in queue order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (pop && (pop_entry.kind == pnorm_pkg::KIND_GAIN)) begin
			gain_q <= pop_entry.data;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop && (pop_entry.kind == pnorm_pkg::KIND_SAMPLE);
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// saturation to the sample range
	assign shifted  = sum_s2 >>> GAIN_FRAC_BITS;
	assign top_bits = shifted[SW-1:SAMPLE_BITS-1];
	always_comb begin
		if ((top_bits == '0) || (top_bits == '1)) begin
			sat = shifted[SAMPLE_BITS-1:0];
		end else if (shifted[SW-1]) begin
			sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	// partial products, sum, saturated result
	always_ff @(posedge clk) begin
		if (adv) begin
			p_lo_s1  <= smp * $signed({1'b0, gain_q[pnorm_pkg::GAIN_LO_BITS-1:0]});
			p_hi_s1  <= smp * $signed({1'b0, gain_q[pnorm_pkg::GAIN_BITS-1:pnorm_pkg::GAIN_LO_BITS]});
			last_s1  <= pop_entry.last;
			sum_s2   <= (SW'(p_hi_s1) <<< pnorm_pkg::GAIN_LO_BITS) + SW'(p_lo_s1);
			last_s2  <= last_s1;
			sample_q <= sat;
			last_q   <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = sample_q;
	assign out_last   = last_q;

endmodule

[hw/rtl/peak_normalizer_core.sv]
// peak_normalizer_core: two-pass peak normalizer, top level
// depends on pnorm_pkg, pnorm_front, pnorm_fifo, pnorm_back
// apply samples: one per cycle if the queue has room; via queue, s1, s2, output reg
// measure samples: one per cycle if the queue has room; the last one of a pass
//   stalls input for the bit-serial divide (not for a zero peak) and the gain load
// reset: peak and gain cleared, target at full scale, queue and pipeline empty
module peak_normalizer_core #(
	parameter int SAMPLE_BITS    = 24,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [SAMPLE_BITS-2:0]           cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// sample_in
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// func
	input  logic                             s_axis_tuser,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// sample_out
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                             m_axis_tlast
);

	localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

	logic [SAMPLE_BITS-2:0] target_q;
	logic                   push_valid;
	logic                   push_ready;
	pnorm_pkg::q_entry_t    push_entry;
	logic                   pop_valid;
	logic                   pop_ready;
	pnorm_pkg::q_entry_t    pop_entry;
	logic [SAMPLE_BITS-1:0] out_sample;

	// target peak register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '1;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	pnorm_front #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tuser),
		.in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
		.in_last   (s_axis_tlast),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	pnorm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	pnorm_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sample(out_sample),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = TDW'(out_sample);

endmodule

[sim/peak_normalizer_core_tb.sv]
// peak_normalizer_core_tb: self-checking stream testbench of the peak normalizer
// measure and apply passes are predicted in-bench and scaled samples checked in order
// depends on pnorm_pkg and peak_normalizer_core
module peak_normalizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W  = 24;
	localparam int FRAC_W = 16;
	localparam int DATA_W = ((SMP_W + 7) / 8) * 8;
	localparam logic [63:0] GAIN_MAX = (64'd1 << pnorm_pkg::GAIN_BITS) - 64'd1;
	localparam logic [63:0] SMP_MAX  = (64'd1 << (SMP_W - 1)) - 64'd1;
	localparam logic [SMP_W-1:0] SMP_POS_FS = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic [SMP_W-1:0] SMP_NEG_FS = {1'b1, {(SMP_W-1){1'b0}}};
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic             func;
		logic [SMP_W-1:0] smp;
		logic             last;
	} norm_req_t;

	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             last;
	} scaled_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [SMP_W-2:0]  cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	// pending requests and expected scaled samples
	norm_req_t pend_req_q[$];
	scaled_t   scaled_q[$];

	// predictor state
	logic [SMP_W-2:0]                tgt_peak = '1;
	logic [SMP_W-1:0]                peak_mag = '0;
	logic [pnorm_pkg::GAIN_BITS-1:0] gain_q16 = '0;

	norm_req_t cur_req;
	logic      drv_busy = 1'b0;
	int        src_gap = 0;
	int        snk_stall = 0;
	int        idle_pct = 0;
	logic      quiet = 1'b0;
	int        req_cnt = 0;
	int        err_cnt = 0;

	peak_normalizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // sample_in
		.s_axis_tuser  (s_axis_tuser),  // func
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // sample_out
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_fail(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// peak tracking, gain division and saturating gain multiply
	task automatic norm_predict(input norm_req_t r);
		logic [SMP_W-1:0] mag;
		logic [63:0]      prod;
		logic [63:0]      q;
		scaled_t          e;
		mag = r.smp[SMP_W-1] ? ~r.smp + 1'b1 : r.smp;
		if (r.func == pnorm_pkg::FUNC_MEASURE) begin
			if (mag > peak_mag)
				peak_mag = mag;
			if (r.last) begin
				// silent pass leaves a zero gain
				if (peak_mag == '0) begin
					gain_q16 = '0;
				end else begin
					q = (64'(tgt_peak) << FRAC_W) / 64'(peak_mag);
					gain_q16 = (q > GAIN_MAX) ? GAIN_MAX[pnorm_pkg::GAIN_BITS-1:0]
						: q[pnorm_pkg::GAIN_BITS-1:0];
				end
				peak_mag = '0;
			end
		end else begin
			prod = 64'(mag) * 64'(gain_q16);
			if (!r.smp[SMP_W-1]) begin
				q = prod >> FRAC_W;
				if (q > SMP_MAX)
					q = SMP_MAX;
				e.smp = q[SMP_W-1:0];
			end else begin
				// negate of the rounded-up magnitude floors toward minus infinity
				q = (prod >> FRAC_W) + 64'(prod[FRAC_W-1:0] != '0);
				if (q > SMP_MAX + 64'd1)
					q = SMP_MAX + 64'd1;
				e.smp = ~q[SMP_W-1:0] + 1'b1;
			end
			e.last = r.last;
			scaled_q.push_back(e);
		end
	endtask

	task automatic add_req(input logic func, input logic [SMP_W-1:0] smp, input logic last);
		norm_req_t r;
		r.func = func;
		r.smp  = smp;
		r.last = last;
		pend_req_q.push_back(r);
		req_cnt++;
	endtask

	function automatic logic [SMP_W-1:0] rand_sample(input int bits);
		logic signed [SMP_W-1:0] s;
		s = SMP_W'($urandom);
		s = s >>> (SMP_W - bits);
		return s;
	endfunction

	// wait until every request is taken and every result is back
	task automatic wait_idle();
		do @(negedge clk);
		while (pend_req_q.size() != 0 || drv_busy || scaled_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_target(input logic [SMP_W-2:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		tgt_peak = v;
		@(negedge clk);
	endtask

	function automatic logic [SMP_W-2:0] pick_target();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return (SMP_W-1)'($urandom);
			default: return (SMP_W-1)'($urandom_range(1, 1023));
		endcase
	endfunction

	// measure pass with random amplitude, occasional apply requests mixed in
	task automatic add_measure_pass();
		int   len;
		int   bits;
		logic silent;
		logic unterminated;
		logic [SMP_W-1:0] s;
		len          = $urandom_range(1, 10);
		bits         = $urandom_range(1, SMP_W);
		silent       = ($urandom_range(9) == 0);
		unterminated = ($urandom_range(9) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(7) == 0)
				add_req(pnorm_pkg::FUNC_APPLY, SMP_W'($urandom), 1'($urandom_range(1)));
			s = silent ? '0 : rand_sample(bits);
			if (!silent && $urandom_range(15) == 0)
				s = $urandom_range(1) ? SMP_POS_FS : SMP_NEG_FS;
			add_req(pnorm_pkg::FUNC_MEASURE, s, (i == len - 1) && !unterminated);
		end
	endtask

	task automatic add_apply_pass();
		int len;
		len = $urandom_range(1, 16);
		for (int i = 0; i < len; i++)
			add_req(pnorm_pkg::FUNC_APPLY, SMP_W'($urandom),
				(i == len - 1) || ($urandom_range(9) == 0));
	endtask

	// source side: one request at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			s_axis_tlast  <= 1'b0;
			drv_busy = 1'b0;
			src_gap  = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				norm_predict(cur_req);
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (pend_req_q.size() != 0) begin
					cur_req  = pend_req_q.pop_front();
					drv_busy = 1'b1;
					s_axis_tdata <= DATA_W'(cur_req.smp);
					s_axis_tuser <= cur_req.func;
					s_axis_tlast <= cur_req.last;
					if (!quiet && $urandom_range(99) < idle_pct)
						src_gap = $urandom_range(1, 9);
				end
			end
			s_axis_tvalid <= drv_busy;
		end
	end

	// sink side: check each scaled sample, stall in random bursts
	always @(posedge clk or negedge arst_n) begin
		scaled_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (scaled_q.size() == 0) begin
					report_fail($sformatf("sample %h with nothing expected", m_axis_tdata));
				end else begin
					want = scaled_q.pop_front();
					if (m_axis_tdata !== DATA_W'(want.smp))
						report_fail($sformatf("sample_out %h, expected %h",
							m_axis_tdata, want.smp));
					if (m_axis_tlast !== want.last)
						report_fail($sformatf("last_out %b, expected %b",
							m_axis_tlast, want.last));
				end
			end
			if (snk_stall != 0)
				snk_stall--;
			else if (!quiet && $urandom_range(99) < idle_pct)
				snk_stall = $urandom_range(1, 9);
			m_axis_tready <= (snk_stall == 0);
		end
	end

	// stimulus
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// apply before any measure pass gives zeros
		idle_pct = 30;
		add_req(pnorm_pkg::FUNC_APPLY, SMP_POS_FS, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, SMP_NEG_FS, 1'b1);
		// peak at negative full scale, gain just under unity
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd100, 1'b0);
		add_req(pnorm_pkg::FUNC_MEASURE, SMP_NEG_FS, 1'b0);
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd0, 1'b0);
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd5, 1'b1);
		add_req(pnorm_pkg::FUNC_APPLY, SMP_POS_FS, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, SMP_NEG_FS, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, 24'hFFFFFF, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, 24'd1, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, 24'd0, 1'b1);
		// silent measure pass
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd0, 1'b0);
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd0, 1'b1);
		add_req(pnorm_pkg::FUNC_APPLY, 24'd12345, 1'b1);

		// tiny peak at full target, products saturate both ways
		write_target('1);
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd1, 1'b1);
		add_req(pnorm_pkg::FUNC_APPLY, 24'd3, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, 24'hFFFFFD, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, SMP_POS_FS, 1'b1);

		// minimal target, negative products round down
		write_target((SMP_W-1)'(1));
		add_req(pnorm_pkg::FUNC_MEASURE, 24'hFFFFFE, 1'b1);
		add_req(pnorm_pkg::FUNC_APPLY, 24'hFFFFFF, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, 24'd1, 1'b0);
		add_req(pnorm_pkg::FUNC_APPLY, SMP_NEG_FS, 1'b1);

		// zero target
		write_target('0);
		add_req(pnorm_pkg::FUNC_MEASURE, 24'd77, 1'b1);
		add_req(pnorm_pkg::FUNC_APPLY, 24'd5000, 1'b1);

		// random phases
		while (req_cnt < 370) begin
			case ($urandom_range(2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			if ($urandom_range(2) == 0)
				write_target(pick_target());
			if ($urandom_range(5) != 0)
				add_measure_pass();
			add_apply_pass();
			@(negedge clk);
		end

		// closing stretch with no idling on either side
		wait_idle();
		quiet    = 1'b1;
		idle_pct = 0;
		write_target(pick_target());
		add_measure_pass();
		add_apply_pass();
		add_measure_pass();
		add_apply_pass();

		do @(negedge clk);
		while (pend_req_q.size() != 0 || drv_busy);
		for (int i = 0; i < 4000 && scaled_q.size() != 0; i++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (scaled_q.size() != 0)
			report_fail($sformatf("%0d scaled samples never arrived", scaled_q.size()));

		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
